[rtl/variable_length_message_fifo_defines.svh]
// Assertion macros for the message queue RTL
`ifndef VARIABLE_LENGTH_MESSAGE_FIFO_DEFINES_SVH
`define VARIABLE_LENGTH_MESSAGE_FIFO_DEFINES_SVH

// Property that must hold at every rising clock edge outside reset
`define VLMF_CHECK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication
`define VLMF_CHECK_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define VLMF_CHECK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/vlmf_pkg.sv]
// Constants and codes for the variable-length message queue
package vlmf_pkg;

    localparam int BUF_BYTES_DEF    = 1024;
    localparam int HEADER_BYTES_DEF = 4;

    // Function codes carried on the input tuser
    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_DATA  = 2'd1;
    localparam logic [1:0] FN_DEQ   = 2'd2;

    // Result kinds carried on the output tuser
    localparam logic [2:0] KIND_ACCEPT  = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_HEADER  = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_EMPTY   = 3'd4;
    localparam logic [2:0] KIND_BUSY    = 3'd5;

    // Configuration register indexes
    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_BUFFER_SIZE = 1'b1;

    localparam logic [10:0] BUFFER_SIZE_RST = 11'd1024;
    localparam logic [5:0]  MAX_DEST        = 6'd62;

    // Byte positions inside a stored header
    localparam int HDR_FLG = 1;
    localparam int HDR_LEN = 2;
    localparam int HDR_SND = 0;

endpackage

[rtl/vlmf_ram.sv]
// Single-port byte store with registered read data
module vlmf_ram #(
    parameter int DEPTH  = vlmf_pkg::BUF_BYTES_DEF,
    parameter int ADDR_W = $clog2(vlmf_pkg::BUF_BYTES_DEF)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Read data holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/variable_length_message_fifo.sv]
// Message queue in a byte ring: enqueue, payload fill and dequeue sequencer
//
//  channel  dir  handshake          contents
//  s_       in   s_tvalid/s_tready  tuser: func; tdata: header fields, byte, capacity
//  m_       out  m_tvalid/m_tready  tuser: kind; tdata: header, count, byte; tlast
//  cfg_     in   cfg_we             cfg_addr selects max_payload or buffer_size
//
//  Enqueue start makes one store write per header byte; a payload byte makes one.
//  Dequeue reads the header bytes (ST_HDR_RD), waits for the last one (ST_HDR_WAIT)
//  and emits the header result (ST_HDR_EMIT), then one payload byte per cycle while
//  the output is not stalled. The unread rest is skipped by a read-pointer jump.
//  A stalled output holds the sequencer; inputs are taken only when it is idle.
//  Reset is synchronous and needs no clearing pass over the store.
`include "variable_length_message_fifo_defines.svh"

module variable_length_message_fifo #(
    parameter int BUF_BYTES    = vlmf_pkg::BUF_BYTES_DEF,
    parameter int HEADER_BYTES = vlmf_pkg::HEADER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sender_id[7:0], msg_flags[15:8], msg_length[23:16], data_byte[31:24],
    // dest_capacity[37:32], zero fill [39:38]
    input  logic [39:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sender_out[7:0], flags_out[15:8], byte_count[23:16], data_out[31:24]
    output logic [31:0] m_tdata,
    // kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_wdata
);

    localparam int PTR_W  = $clog2(BUF_BYTES);
    localparam int CNT_W  = $clog2(BUF_BYTES + 1);
    localparam int SUM_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int HIDX_W = $clog2(HEADER_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_WR,
        ST_HDR_RD,
        ST_HDR_WAIT,
        ST_HDR_EMIT,
        ST_PAY
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [7:0]         bts_reg, bts_next;
    logic [7:0]         maxp_reg, maxp_next;
    logic [10:0]        bsize_reg, bsize_next;
    logic [HIDX_W-1:0]  hidx_reg, hidx_next;
    logic [HIDX_W-1:0]  rd_hidx_reg, rd_hidx_next;
    logic               rd_hv_reg, rd_hv_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [7:0]         snd_reg, snd_next;
    logic [7:0]         flg_reg, flg_next;
    logic [7:0]         len_reg, len_next;
    logic [5:0]         dcap_reg, dcap_next;
    logic [5:0]         res_reg, res_next;
    logic [7:0]         drop_reg, drop_next;
    logic [5:0]         iss_reg, iss_next;
    logic [5:0]         mov_reg, mov_next;
    logic               m_valid_reg, m_valid_next;
    logic [2:0]         m_kind_reg, m_kind_next;
    logic [31:0]        m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    logic               ram_we, ram_re;
    logic [PTR_W-1:0]   ram_addr;
    logic [7:0]         ram_wdata, ram_rdata;

    logic [CNT_W-1:0]   ring_cap;
    logic [7:0]         n_w;
    logic [SUM_W-1:0]   free_w, need_w, tot_w;
    logic               trunc_w;
    logic [7:0]         hl_w, drop_w;
    logic [5:0]         res_w;
    logic               out_free, s_acc, move_w, issue_w;

    logic [7:0]         in_snd, in_flg, in_len, in_dat;
    logic [5:0]         in_cap;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] q;
        q = CNT_W'(p) + CNT_W'(1);
        return (q >= c) ? '0 : PTR_W'(q);
    endfunction

    function automatic logic [PTR_W-1:0] skip(input logic [PTR_W-1:0] p,
                                              input logic [7:0]       d,
                                              input logic [CNT_W-1:0] c);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(d);
        if (s >= SUM_W'(c)) begin
            s = s - SUM_W'(c);
        end
        return PTR_W'(s);
    endfunction

    vlmf_ram #(
        .DEPTH  (BUF_BYTES),
        .ADDR_W (PTR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_snd = s_tdata[7:0];
    assign in_flg = s_tdata[15:8];
    assign in_len = s_tdata[23:16];
    assign in_dat = s_tdata[31:24];
    assign in_cap = s_tdata[37:32];

    assign ring_cap = ({21'd0, bsize_reg} > 32'(BUF_BYTES)) ? CNT_W'(BUF_BYTES)
                                                           : CNT_W'(bsize_reg);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;

    // Enqueue sizing
    assign n_w    = (maxp_reg != 8'd0 && in_len > maxp_reg) ? maxp_reg : in_len;
    assign free_w = (used_reg < ring_cap) ? SUM_W'(ring_cap - used_reg) : '0;
    assign need_w = SUM_W'(HEADER_BYTES) + SUM_W'(n_w);

    // Dequeue sizing: clip a header length that runs past the stored bytes
    assign tot_w   = SUM_W'(HEADER_BYTES) + SUM_W'(len_reg);
    assign trunc_w = tot_w > SUM_W'(used_reg);
    assign hl_w    = trunc_w ? 8'(SUM_W'(used_reg) - SUM_W'(HEADER_BYTES)) : len_reg;
    assign res_w   = (hl_w < {2'b00, dcap_reg}) ? 6'(hl_w) : dcap_reg;
    assign drop_w  = hl_w - {2'b00, res_w};

    assign move_w  = rd_pend_reg && out_free;
    assign issue_w = (iss_reg < res_reg) && (!rd_pend_reg || move_w);

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        used_next    = used_reg;
        bts_next     = bts_reg;
        maxp_next    = maxp_reg;
        bsize_next   = bsize_reg;
        hidx_next    = hidx_reg;
        rd_hidx_next = rd_hidx_reg;
        rd_hv_next   = 1'b0;
        rd_pend_next = rd_pend_reg;
        snd_next     = snd_reg;
        flg_next     = flg_reg;
        len_next     = len_reg;
        dcap_next    = dcap_reg;
        res_next     = res_reg;
        drop_next    = drop_reg;
        iss_next     = iss_reg;
        mov_next     = mov_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = wp_reg;
        ram_wdata    = 8'd0;

        // Capture header bytes as they come back from the store
        if (rd_hv_reg) begin
            if (rd_hidx_reg == HIDX_W'(vlmf_pkg::HDR_SND)) begin
                snd_next = ram_rdata;
            end else if (rd_hidx_reg == HIDX_W'(vlmf_pkg::HDR_FLG)) begin
                flg_next = ram_rdata;
            end else if (rd_hidx_reg == HIDX_W'(vlmf_pkg::HDR_LEN)) begin
                len_next = ram_rdata;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        vlmf_pkg::FN_START: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b0;
                            m_data_next  = 32'd0;
                            if (bts_reg != 8'd0) begin
                                m_kind_next = vlmf_pkg::KIND_BUSY;
                            end else if (free_w < need_w) begin
                                m_kind_next = vlmf_pkg::KIND_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                ram_addr    = wp_reg;
                                ram_wdata   = in_snd;
                                wp_next     = adv(wp_reg, ring_cap);
                                flg_next    = in_flg;
                                len_next    = n_w;
                                used_next   = CNT_W'(SUM_W'(used_reg) + need_w);
                                bts_next    = n_w;
                                hidx_next   = HIDX_W'(1);
                                m_kind_next = vlmf_pkg::KIND_ACCEPT;
                                m_data_next = {8'd0, n_w, 16'd0};
                                state_next  = ST_HDR_WR;
                            end
                        end
                        vlmf_pkg::FN_DATA: begin
                            if (bts_reg != 8'd0) begin
                                ram_we    = 1'b1;
                                ram_addr  = wp_reg;
                                ram_wdata = in_dat;
                                wp_next   = adv(wp_reg, ring_cap);
                                bts_next  = bts_reg - 8'd1;
                            end
                        end
                        vlmf_pkg::FN_DEQ: begin
                            if (bts_reg != 8'd0) begin
                                m_valid_next = 1'b1;
                                m_kind_next  = vlmf_pkg::KIND_BUSY;
                                m_data_next  = 32'd0;
                                m_last_next  = 1'b1;
                            end else if (SUM_W'(used_reg) < SUM_W'(HEADER_BYTES)) begin
                                m_valid_next = 1'b1;
                                m_kind_next  = vlmf_pkg::KIND_EMPTY;
                                m_data_next  = 32'd0;
                                m_last_next  = 1'b1;
                            end else begin
                                dcap_next  = (in_cap > vlmf_pkg::MAX_DEST) ? vlmf_pkg::MAX_DEST
                                                                           : in_cap;
                                hidx_next  = '0;
                                state_next = ST_HDR_RD;
                            end
                        end
                        default: begin
                            // unused function: drop the transfer
                        end
                    endcase
                end
            end
            ST_HDR_WR: begin
                ram_we   = 1'b1;
                ram_addr = wp_reg;
                if (hidx_reg == HIDX_W'(vlmf_pkg::HDR_FLG)) begin
                    ram_wdata = flg_reg;
                end else if (hidx_reg == HIDX_W'(vlmf_pkg::HDR_LEN)) begin
                    ram_wdata = len_reg;
                end
                wp_next   = adv(wp_reg, ring_cap);
                hidx_next = hidx_reg + HIDX_W'(1);
                if (hidx_reg == HIDX_W'(HEADER_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HDR_RD: begin
                ram_re       = 1'b1;
                ram_addr     = rp_reg;
                rp_next      = adv(rp_reg, ring_cap);
                rd_hv_next   = 1'b1;
                rd_hidx_next = hidx_reg;
                hidx_next    = hidx_reg + HIDX_W'(1);
                if (hidx_reg == HIDX_W'(HEADER_BYTES - 1)) begin
                    state_next = ST_HDR_WAIT;
                end
            end
            ST_HDR_WAIT: begin
                // last header byte lands this cycle
                state_next = ST_HDR_EMIT;
            end
            ST_HDR_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = vlmf_pkg::KIND_HEADER;
                    m_data_next  = {8'd0, 2'b00, res_w, flg_reg, snd_reg};
                    m_last_next  = (res_w == 6'd0);
                    used_next    = used_reg - (trunc_w ? used_reg : CNT_W'(tot_w));
                    res_next     = res_w;
                    drop_next    = drop_w;
                    iss_next     = 6'd0;
                    mov_next     = 6'd0;
                    if (res_w == 6'd0) begin
                        rp_next    = skip(rp_reg, drop_w, ring_cap);
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_PAY;
                    end
                end
            end
            ST_PAY: begin
                if (issue_w) begin
                    ram_re   = 1'b1;
                    ram_addr = rp_reg;
                    rp_next  = adv(rp_reg, ring_cap);
                    iss_next = iss_reg + 6'd1;
                end
                rd_pend_next = issue_w || (rd_pend_reg && !move_w);
                if (move_w) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = vlmf_pkg::KIND_PAYLOAD;
                    m_data_next  = {ram_rdata, 24'd0};
                    m_last_next  = (mov_reg + 6'd1 == res_reg);
                    mov_next     = mov_reg + 6'd1;
                    if (mov_reg + 6'd1 == res_reg) begin
                        // drop the unread rest of the message
                        rp_next    = skip(rp_reg, drop_reg, ring_cap);
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            unique case (cfg_addr)
                vlmf_pkg::CFG_MAX_PAYLOAD: begin
                    maxp_next = cfg_wdata[7:0];
                end
                vlmf_pkg::CFG_BUFFER_SIZE: begin
                    bsize_next = cfg_wdata;
                    wp_next    = '0;
                    rp_next    = '0;
                    used_next  = '0;
                    bts_next   = 8'd0;
                end
                default: begin
                    maxp_next = maxp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            used_reg    <= '0;
            bts_reg     <= 8'd0;
            maxp_reg    <= 8'd0;
            bsize_reg   <= vlmf_pkg::BUFFER_SIZE_RST;
            hidx_reg    <= '0;
            rd_hv_reg   <= 1'b0;
            rd_pend_reg <= 1'b0;
            iss_reg     <= 6'd0;
            mov_reg     <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            used_reg    <= used_next;
            bts_reg     <= bts_next;
            maxp_reg    <= maxp_next;
            bsize_reg   <= bsize_next;
            hidx_reg    <= hidx_next;
            rd_hv_reg   <= rd_hv_next;
            rd_pend_reg <= rd_pend_next;
            iss_reg     <= iss_next;
            mov_reg     <= mov_next;
            m_valid_reg <= m_valid_next;
            rd_hidx_reg <= rd_hidx_next;
            snd_reg     <= snd_next;
            flg_reg     <= flg_next;
            len_reg     <= len_next;
            dcap_reg    <= dcap_next;
            res_reg     <= res_next;
            drop_reg    <= drop_next;
            m_kind_reg  <= m_kind_next;
            m_data_reg  <= m_data_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `VLMF_CHECK(a_used_within_cap, aclk, aresetn, used_reg <= ring_cap, "used bytes exceed ring size")
    `VLMF_CHECK_IMP(a_pay_read_track, aclk, aresetn, state_reg == ST_PAY, iss_reg == mov_reg + {5'd0, rd_pend_reg}, "payload reads and transfers out of step")
    `VLMF_CHECK_IMP(a_deq_not_filling, aclk, aresetn, state_reg == ST_HDR_RD, bts_reg == 8'd0, "dequeue while payload still expected")
    `VLMF_CHECK_NEXT(a_header_emitted, aclk, aresetn, state_reg == ST_HDR_EMIT && out_free, m_tvalid && m_tuser == vlmf_pkg::KIND_HEADER, "header result missing")

endmodule
